// ===== sv/disparity_hole_fill_assert.svh =====
// Assertion macros for the disparity hole filler.
// Both macros sample on the rising edge of clk. The reset-qualified form is
// disabled while rst_n is low. The other form also holds during reset.
`ifndef DISPARITY_HOLE_FILL_ASSERT_SVH
`define DISPARITY_HOLE_FILL_ASSERT_SVH
`ifndef SYNTHESIS
`define DHF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DHF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DHF_ASSERT(label, prop, msg)
`define DHF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/dhf_pkg.sv =====
package dhf_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    localparam logic [1:0] CFG_FRAME_COLS = 2'd0;
    localparam logic [1:0] CFG_FRAME_ROWS = 2'd1;

    localparam int COLS_REG_W = 11;
    localparam int ROWS_REG_W = 10;
    localparam int CFG_DATA_W = 11;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd640;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 10'd480;

    // Common multiple of every sample count from 1 to 16. Any common multiple
    // gives the same floor, so one value serves every sample limit.
    localparam int COMMON_DEN = 720720;
    localparam int RECIP_W    = 20;
    localparam int TOTAL_W    = 30;
    localparam int QUOT_W     = 8;
    localparam int FILL_DIVISOR = 4 * COMMON_DEN;

    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] data;
    } mem_cmd_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [4:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            5'd1:    r = 20'd720720;
            5'd2:    r = 20'd360360;
            5'd3:    r = 20'd240240;
            5'd4:    r = 20'd180180;
            5'd5:    r = 20'd144144;
            5'd6:    r = 20'd120120;
            5'd7:    r = 20'd102960;
            5'd8:    r = 20'd90090;
            5'd9:    r = 20'd80080;
            5'd10:   r = 20'd72072;
            5'd11:   r = 20'd65520;
            5'd12:   r = 20'd60060;
            5'd13:   r = 20'd55440;
            5'd14:   r = 20'd51480;
            5'd15:   r = 20'd48048;
            5'd16:   r = 20'd45045;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/dhf_frame_ram.sv =====
module dhf_frame_ram #(
    parameter int AW = 19
) (
    input  logic              clk,
    input  logic [AW-1:0]     addr,
    input  dhf_pkg::mem_cmd_t cmd,
    output logic [7:0]        rdata
);
    import dhf_pkg::*;

    logic [7:0] mem [0:(1 << AW)-1];

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            if (cmd.we)
            begin
                mem[addr] <= cmd.data;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end
endmodule

// ===== sv/dhf_div.sv =====
module dhf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [dhf_pkg::TOTAL_W-1:0] dividend,
    output logic                      done,
    output logic [dhf_pkg::QUOT_W-1:0] quotient
);
    import dhf_pkg::*;

    localparam int RECIP_SHIFT = 52;
    localparam int RECIP_MW    = 31;
    localparam int PROD_W      = TOTAL_W + RECIP_MW;
    localparam logic [RECIP_MW-1:0] RECIP_M = RECIP_MW'(
        ((64'd1 << RECIP_SHIFT) + 64'(FILL_DIVISOR) - 64'd1) / 64'(FILL_DIVISOR));

    logic               active_reg;
    logic [TOTAL_W-1:0] dividend_reg;
    logic [PROD_W-1:0]  product;

    // Division by the constant 4 * COMMON_DEN through a rounded-up reciprocal.
    // The rounding error of the reciprocal times the largest total stays below
    // 2**RECIP_SHIFT, so the upper product bits are the exact floor.
    assign product = {{RECIP_MW{1'b0}}, dividend_reg} * {{TOTAL_W{1'b0}}, RECIP_M};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done       <= 1'b0;
        end
        else
        begin
            done       <= 1'b0;
            active_reg <= start;
            if (start)
            begin
                dividend_reg <= dividend;
            end
            if (active_reg)
            begin
                quotient <= product[RECIP_SHIFT +: QUOT_W];
                done     <= 1'b1;
            end
        end
    end
endmodule

// ===== sv/dhf_fill.sv =====
module dhf_fill #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 512,
    parameter int SAMPLES  = 10,
    parameter int AW = $clog2(MAX_COLS * MAX_ROWS),
    parameter int CW = $clog2(MAX_COLS + 1),
    parameter int RW = $clog2(MAX_ROWS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CW-1:0]     cols,
    input  logic [RW-1:0]     rows,
    input  logic [7:0]        rdata,
    output logic [AW-1:0]     addr,
    output dhf_pkg::mem_cmd_t cmd,
    output logic              done
);
    import dhf_pkg::*;

    localparam int CIW = $clog2(MAX_COLS);
    localparam int RIW = $clog2(MAX_ROWS);
    localparam int NW  = $clog2(SAMPLES + 1);
    localparam int SW  = $clog2(SAMPLES * 255 + 1);
    localparam logic [NW-1:0] N_MAX = NW'(SAMPLES);

    typedef enum logic [3:0] {
        S_IDLE, S_PIX_RD, S_PIX_CHK, S_DIR_INIT, S_SMP, S_FIN, S_ACC,
        S_DIV, S_WRITE, S_NEXT, S_DONE
    } state_t;

    state_t               state_reg;
    logic [RIW-1:0]       r_reg, sr_reg;
    logic [CIW-1:0]       c_reg, sc_reg;
    logic [AW-1:0]        base_reg, saddr_reg;
    logic [1:0]           dir_reg;
    logic [NW-1:0]        cnt_reg;
    logic [SW-1:0]        sum_reg;
    logic [TOTAL_W-1:0]   prod_reg, total_reg;
    logic                 div_start;
    logic                 div_done;
    logic [QUOT_W-1:0]    quot;

    logic                 step_ok;
    logic [RIW-1:0]       step_r;
    logic [CIW-1:0]       step_c;
    logic [AW-1:0]        step_addr;
    logic [NW-1:0]        cnt_next;
    logic [SW-1:0]        sum_next;
    logic                 last_col, last_row;

    // One step of the scan in the current direction: right, left, down, up.
    always_comb
    begin
        step_r    = sr_reg;
        step_c    = sc_reg;
        step_addr = saddr_reg;
        step_ok   = 1'b0;
        case (dir_reg)
            2'd0:
            begin
                step_ok   = (CW'(sc_reg) + CW'(1)) < cols;
                step_c    = sc_reg + CIW'(1);
                step_addr = saddr_reg + AW'(1);
            end
            2'd1:
            begin
                step_ok   = sc_reg != '0;
                step_c    = sc_reg - CIW'(1);
                step_addr = saddr_reg - AW'(1);
            end
            2'd2:
            begin
                step_ok   = (RW'(sr_reg) + RW'(1)) < rows;
                step_r    = sr_reg + RIW'(1);
                step_addr = saddr_reg + AW'(cols);
            end
            default:
            begin
                step_ok   = sr_reg != '0;
                step_r    = sr_reg - RIW'(1);
                step_addr = saddr_reg - AW'(cols);
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (rdata != 8'd0)
        begin
            cnt_next = cnt_reg + NW'(1);
            sum_next = sum_reg + SW'(rdata);
        end
    end

    assign last_col  = (CW'(c_reg) + CW'(1)) == cols;
    assign last_row  = (RW'(r_reg) + RW'(1)) == rows;
    assign div_start = (state_reg == S_ACC) && (dir_reg == 2'd3);

    always_comb
    begin
        addr     = base_reg;
        cmd.en   = 1'b0;
        cmd.we   = 1'b0;
        cmd.data = quot;
        case (state_reg)
            S_PIX_RD:   cmd.en = 1'b1;
            S_DIR_INIT:
            begin
                addr   = step_addr;
                cmd.en = step_ok;
            end
            S_SMP:
            begin
                addr   = step_addr;
                cmd.en = step_ok && (cnt_next != N_MAX);
            end
            S_WRITE:
            begin
                cmd.en = 1'b1;
                cmd.we = 1'b1;
            end
            default:    cmd.en = 1'b0;
        endcase
    end

    dhf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg + prod_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        r_reg     <= '0;
                        c_reg     <= '0;
                        base_reg  <= '0;
                        state_reg <= S_PIX_RD;
                    end
                end
                S_PIX_RD:  state_reg <= S_PIX_CHK;
                S_PIX_CHK:
                begin
                    sr_reg    <= r_reg;
                    sc_reg    <= c_reg;
                    saddr_reg <= base_reg;
                    dir_reg   <= 2'd0;
                    total_reg <= '0;
                    state_reg <= (rdata != 8'd0) ? S_NEXT : S_DIR_INIT;
                end
                S_DIR_INIT:
                begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    if (step_ok)
                    begin
                        sr_reg    <= step_r;
                        sc_reg    <= step_c;
                        saddr_reg <= step_addr;
                        state_reg <= S_SMP;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_SMP:
                begin
                    cnt_reg <= cnt_next;
                    sum_reg <= sum_next;
                    if (step_ok && (cnt_next != N_MAX))
                    begin
                        sr_reg    <= step_r;
                        sc_reg    <= step_c;
                        saddr_reg <= step_addr;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    prod_reg  <= TOTAL_W'(sum_reg * recip_of(5'(cnt_reg)));
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sr_reg    <= r_reg;
                    sc_reg    <= c_reg;
                    saddr_reg <= base_reg;
                    if (dir_reg == 2'd3)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        total_reg <= total_reg + prod_reg;
                        dir_reg   <= dir_reg + 2'd1;
                        state_reg <= S_DIR_INIT;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:   state_reg <= S_NEXT;
                S_NEXT:
                begin
                    base_reg <= base_reg + AW'(1);
                    if (last_col)
                    begin
                        c_reg <= '0;
                        if (last_row)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            r_reg     <= r_reg + RIW'(1);
                            state_reg <= S_PIX_RD;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + CIW'(1);
                        state_reg <= S_PIX_RD;
                    end
                end
                S_DONE:
                begin
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/disparity_hole_fill.sv =====
// Disparity hole filler. A transaction is taken at a clock edge where start
// is high and busy is low, and kind selects its meaning: load stores
// pixel_in at the next raster position, read returns the next raster pixel,
// and run fills every zero pixel in place from the mean of up to
// SAMPLES_PER_DIRECTION nonzero neighbors in each of the four directions.
// Load and read transactions are taken one per cycle while no run holds busy
// high, since each makes one access to the single-port frame memory. A read
// result appears on pixel_out, with result_valid high, in the cycle after it
// was taken. A run holds busy high while its sequencer walks the frame
// through that memory, reading each pixel and, for each hole, scanning the
// four directions and then waiting on the divider, which divides by a
// constant through a reciprocal multiply.
// The run's result shows with fill_done high in the same cycle in which busy
// falls low again.
// Results are strobes of exactly one cycle and the receiver cannot stall
// them, so it must take each one in the cycle it appears. The frame memory
// is not cleared at reset; pixels never loaded read as unknown values.
module disparity_hole_fill #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 512,
    parameter int SAMPLES_PER_DIRECTION = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     kind,
    input  logic [7:0]                     pixel_in,
    output logic                           result_valid,
    output logic [7:0]                     pixel_out,
    output logic                           fill_done,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dhf_pkg::*;

    localparam int AW = $clog2(MAX_COLS * MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [COLS_REG_W-1:0] cols_reg;
    logic [ROWS_REG_W-1:0] rows_reg;
    logic [AW-1:0]         load_pos_reg, read_pos_reg;
    logic                  busy_reg;
    logic                  rd_pend_reg;
    logic                  run_done_reg;

    logic [CW-1:0]  eff_cols;
    logic [RW-1:0]  eff_rows;
    logic [AW:0]    frame_size;
    logic [AW-1:0]  load_use, read_use, load_next, read_next;
    logic           accept;
    kind_t          kind_in;

    logic [AW-1:0]  eng_addr, mem_addr;
    mem_cmd_t       eng_cmd, host_cmd, mem_cmd;
    logic [7:0]     mem_rdata;
    logic           eng_done;

    // Registers are used clamped to the range of 1 up to the frame maximum.
    always_comb
    begin
        if (cols_reg == '0)
            eff_cols = CW'(1);
        else if (32'(cols_reg) > MAX_COLS)
            eff_cols = CW'(MAX_COLS);
        else
            eff_cols = CW'(cols_reg);
        if (rows_reg == '0)
            eff_rows = RW'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            eff_rows = RW'(MAX_ROWS);
        else
            eff_rows = RW'(rows_reg);
    end

    assign frame_size = (AW+1)'(eff_cols * eff_rows);

    // A position left beyond the frame by a size change restarts at zero.
    assign load_use  = ({1'b0, load_pos_reg} >= frame_size) ? '0 : load_pos_reg;
    assign read_use  = ({1'b0, read_pos_reg} >= frame_size) ? '0 : read_pos_reg;
    assign load_next = (({1'b0, load_use} + (AW+1)'(1)) >= frame_size) ?
                       '0 : load_use + AW'(1);
    assign read_next = (({1'b0, read_use} + (AW+1)'(1)) >= frame_size) ?
                       '0 : read_use + AW'(1);

    assign kind_in = kind_t'(kind);
    assign accept  = start && !busy_reg;
    assign busy    = busy_reg;

    always_comb
    begin
        host_cmd.en   = 1'b0;
        host_cmd.we   = 1'b0;
        host_cmd.data = pixel_in;
        mem_addr      = read_use;
        if (accept)
        begin
            case (kind_in)
                KIND_LOAD:
                begin
                    host_cmd.en = 1'b1;
                    host_cmd.we = 1'b1;
                    mem_addr    = load_use;
                end
                KIND_READ:
                begin
                    host_cmd.en = 1'b1;
                end
                default:
                begin
                    host_cmd.en = 1'b0;
                end
            endcase
        end
        if (busy_reg)
        begin
            mem_addr = eng_addr;
        end
    end

    assign mem_cmd = busy_reg ? eng_cmd : host_cmd;

    dhf_frame_ram #(
        .AW (AW)
    ) u_ram (
        .clk   (clk),
        .addr  (mem_addr),
        .cmd   (mem_cmd),
        .rdata (mem_rdata)
    );

    dhf_fill #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .SAMPLES  (SAMPLES_PER_DIRECTION)
    ) u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && (kind_in == KIND_RUN)),
        .cols  (eff_cols),
        .rows  (eff_rows),
        .rdata (mem_rdata),
        .addr  (eng_addr),
        .cmd   (eng_cmd),
        .done  (eng_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= COLS_RESET;
            rows_reg     <= ROWS_RESET;
            load_pos_reg <= '0;
            read_pos_reg <= '0;
            busy_reg     <= 1'b0;
            rd_pend_reg  <= 1'b0;
            run_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_COLS: cols_reg <= COLS_REG_W'(cfg_data);
                    CFG_FRAME_ROWS: rows_reg <= ROWS_REG_W'(cfg_data);
                    default:        cols_reg <= cols_reg;
                endcase
            end
            rd_pend_reg  <= accept && (kind_in == KIND_READ);
            run_done_reg <= eng_done;
            if (eng_done)
            begin
                busy_reg <= 1'b0;
            end
            if (accept)
            begin
                case (kind_in)
                    KIND_LOAD: load_pos_reg <= load_next;
                    KIND_READ: read_pos_reg <= read_next;
                    KIND_RUN:  busy_reg     <= 1'b1;
                    default:   busy_reg     <= busy_reg;
                endcase
            end
        end
    end

    // A read result and a run result never share a cycle.
    assign result_valid = rd_pend_reg || run_done_reg;
    assign pixel_out    = rd_pend_reg ? mem_rdata : 8'd0;
    assign fill_done    = run_done_reg;

`include "disparity_hole_fill_assert.svh"

    `DHF_ASSERT_ALWAYS(a_one_result, !(rd_pend_reg && run_done_reg), "two results at once")
    `DHF_ASSERT(a_run_busy, (accept && (kind_in == KIND_RUN)) |=> busy_reg, "run not busy")
    `DHF_ASSERT(a_busy_src, $rose(busy_reg) |-> $past(start), "busy without start")
    `DHF_ASSERT(a_done_end, run_done_reg |-> !busy_reg && $past(busy_reg), "stray run result")

endmodule
